// ===== hw/rtl/deq_pkg.sv =====
// Package for the double-ended queue: sizes, operation and status codes,
// and the packed beat types of the input and result channels.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_BACK   = 2'd2,
        MODE_POP_FRONT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] removed_value;
        logic [4:0]         count;
        logic               is_empty;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Double-ended queue: circular element store in one synchronous memory
// plus head, tail and occupancy registers. Depends on deq_pkg.
// Input to result: memory read, then result register. Throughput: one
// operation per cycle unless the result channel stalls; pointers and
// occupancy update at accept, the single memory port serves the beat.
// Reset: clears pointers, occupancy and valid flags; store left undefined.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out
);

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // Stage 1: metadata while the memory read completes
    logic                         r_s1_valid;
    t_status                      r_s1_status;
    logic                         r_s1_pop_ok;
    logic [CNT_W-1:0]             r_s1_count;
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    logic      r_out_valid;
    t_out_beat r_out;

    logic             accept;
    logic             s1_advance;
    logic             is_full;
    logic             is_empty_now;
    logic             wr_en;
    logic             rd_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] head_prev;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_prev;
    logic [PTR_W-1:0] tail_next;
    t_status          status;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign accept     = i_in_valid && o_in_ready;

    assign is_full      = (r_count == CNT_W'(DEPTH));
    assign is_empty_now = (r_count == '0);

    assign head_prev = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_next = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_prev = (r_tail == '0) ? PTR_W'(DEPTH - 1) : r_tail - 1'b1;
    assign tail_next = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_addr = r_tail;
        rd_addr = r_head;
        status  = ST_OK;
        unique case (i_in.mode)
            MODE_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_PUSH_FULL;
                end else begin
                    wr_en   = accept;
                    wr_addr = r_tail;
                    n_tail  = tail_next;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_PUSH_FULL;
                end else begin
                    wr_en   = accept;
                    wr_addr = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (is_empty_now) begin
                    status = ST_POP_EMPTY;
                end else begin
                    rd_en   = accept;
                    rd_addr = tail_prev;
                    n_tail  = tail_prev;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (is_empty_now) begin
                    status = ST_POP_EMPTY;
                end else begin
                    rd_en   = accept;
                    rd_addr = r_head;
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // A pop reads a slot filled by an earlier accepted push, so the write
    // has landed before the read: no forwarding needed.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= DATA_WIDTH'(i_in.value);
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= status;
            r_s1_pop_ok <= rd_en;
            r_s1_count  <= n_count;
        end
        if (s1_advance) begin
            r_out.status        <= r_s1_status;
            r_out.removed_value <= r_s1_pop_ok ? 32'(r_rd_data) : '0;
            r_out.count         <= 5'(r_s1_count);
            r_out.is_empty      <= (r_s1_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail disagree with occupancy");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("stalled stage 1 lost its beat");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("read and write issued together");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_empty == (r_out.count == 5'd0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire
